// ----- rtl/core/rc4s_pkg.sv -----
package rc4s_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY3_W     = 48;
  localparam int unsigned KEY_FLAT_W = 256;
  localparam int unsigned KEY_SEL_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd3;

  typedef struct packed {
    logic init;
    logic cap_in;
    logic fill;
    logic rd_n;
    logic wr_prev;
    logic upd_j;
    logic keyed;
    logic wr_j;
    logic adv_n;
    logic rd_i;
    logic clr_j;
    logic rd_t;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic n_last;
    logic n_zero;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/rc4s_ctrl.sv -----
module rc4s_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             first_of_message_i,
  output logic             in_ready_o,
  input  rc4s_pkg::status_t st_i,
  output rc4s_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FILL   = 4'd1;
  localparam logic [3:0] ST_SCH_A  = 4'd2;
  localparam logic [3:0] ST_SCH_B  = 4'd3;
  localparam logic [3:0] ST_SCH_C  = 4'd4;
  localparam logic [3:0] ST_SCH_D  = 4'd5;
  localparam logic [3:0] ST_BYTE_B = 4'd6;
  localparam logic [3:0] ST_BYTE_C = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FIN) && st_i.out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap_in = 1'b1;
          if (first_of_message_i) begin
            cmd_o.init = 1'b1;
            state_d    = ST_FILL;
          end else begin
            cmd_o.rd_i = 1'b1;
            state_d    = ST_BYTE_B;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (st_i.n_last) begin
          state_d = ST_SCH_A;
        end
      end
      ST_SCH_A: begin
        cmd_o.rd_n    = 1'b1;
        cmd_o.wr_prev = !st_i.n_zero;
        state_d       = ST_SCH_B;
      end
      ST_SCH_B: begin
        cmd_o.upd_j = 1'b1;
        cmd_o.keyed = 1'b1;
        state_d     = ST_SCH_C;
      end
      ST_SCH_C: begin
        cmd_o.wr_j  = 1'b1;
        cmd_o.adv_n = 1'b1;
        state_d     = st_i.n_last ? ST_SCH_D : ST_SCH_A;
      end
      ST_SCH_D: begin
        cmd_o.wr_prev = 1'b1;
        cmd_o.rd_i    = 1'b1;
        cmd_o.clr_j   = 1'b1;
        state_d       = ST_BYTE_B;
      end
      ST_BYTE_B: begin
        cmd_o.upd_j = 1'b1;
        state_d     = ST_BYTE_C;
      end
      ST_BYTE_C: begin
        cmd_o.wr_j = 1'b1;
        cmd_o.rd_t = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (st_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
          if (accept) begin
            cmd_o.cap_in = 1'b1;
            if (first_of_message_i) begin
              cmd_o.init = 1'b1;
              state_d    = ST_FILL;
            end else begin
              cmd_o.rd_i = 1'b1;
              state_d    = ST_BYTE_B;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/rc4s_dp.sv -----
module rc4s_dp #(
  parameter int unsigned TABLE_SIZE = 128,
  parameter int unsigned KEY_BYTES  = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4s_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                      data_in_i,
  output logic [7:0]                      data_out_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  rc4s_pkg::cmd_t                  cmd_i,
  output rc4s_pkg::status_t               st_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned RW = IW + 5;
  localparam int unsigned KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
  localparam logic [KW-1:0] LAST_KEY = KW'(KEY_BYTES - 1);

  function automatic logic [IW-1:0] mod_t(input logic [RW-1:0] x);
    logic [RW-1:0] r;
    r = x;
    for (int k = 4; k >= 0; k--) begin
      if (r >= RW'(TABLE_SIZE << k)) begin
        r = r - RW'(TABLE_SIZE << k);
      end
    end
    return r[IW-1:0];
  endfunction

  logic [rc4s_pkg::CFG_DATA_W-1:0] key0_q, key1_q, key2_q;
  logic [rc4s_pkg::KEY3_W-1:0]     key3_q;
  logic [rc4s_pkg::KEY_FLAT_W-1:0] key_flat;

  logic [IW-1:0] mem [TABLE_SIZE];
  logic [IW-1:0] rd_data_q;
  logic [IW-1:0] rd_addr, wr_addr, wr_data;
  logic          rd_en, wr_en;

  logic [IW-1:0] i_q, j_q, n_q, pn_q, si_q, sj_q, t_q;
  logic [KW-1:0] kidx_q;
  logic [7:0]    data_q;
  logic [7:0]    out_data_q;
  logic          out_valid_q;

  logic [IW-1:0] i_nxt, n_nxt, j_new, t_val, ks;
  logic [KW-1:0] kidx_nxt;
  logic [7:0]    kb, kb_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
      key3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rc4s_pkg::CFG_KEY_WORD0: key0_q <= cfg_data_i;
        rc4s_pkg::CFG_KEY_WORD1: key1_q <= cfg_data_i;
        rc4s_pkg::CFG_KEY_WORD2: key2_q <= cfg_data_i;
        rc4s_pkg::CFG_KEY_WORD3: key3_q <= cfg_data_i[rc4s_pkg::KEY3_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_flat = {16'h0000, key3_q, key2_q, key1_q, key0_q};
  assign kb       = key_flat[8*rc4s_pkg::KEY_SEL_W'(kidx_q) +: 8];
  assign kb_term  = cmd_i.keyed ? kb : 8'h00;

  assign i_nxt    = (i_q == LAST_IDX) ? '0 : i_q + 1'b1;
  assign n_nxt    = (n_q == LAST_IDX) ? '0 : n_q + 1'b1;
  assign kidx_nxt = (kidx_q == LAST_KEY) ? '0 : kidx_q + 1'b1;
  assign j_new    = mod_t(RW'(j_q) + RW'(rd_data_q) + RW'(kb_term));
  assign t_val    = mod_t(RW'(si_q) + RW'(rd_data_q));

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = n_q;
    if (cmd_i.rd_n) begin
      rd_addr = n_q;
    end else if (cmd_i.upd_j) begin
      rd_addr = j_new;
    end else if (cmd_i.rd_i) begin
      rd_addr = i_nxt;
    end else if (cmd_i.rd_t) begin
      rd_addr = t_val;
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = n_q;
    wr_data = n_q;
    if (cmd_i.fill) begin
      wr_addr = n_q;
      wr_data = n_q;
    end else if (cmd_i.wr_prev) begin
      wr_addr = pn_q;
      wr_data = sj_q;
    end else if (cmd_i.wr_j) begin
      wr_addr = j_q;
      wr_data = si_q;
    end else if (cmd_i.fin) begin
      wr_addr = i_q;
      wr_data = sj_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      if (cmd_i.init) begin
        i_q <= '0;
      end else if (cmd_i.rd_i) begin
        i_q <= i_nxt;
      end
      if (cmd_i.init || cmd_i.clr_j) begin
        j_q <= '0;
      end else if (cmd_i.upd_j) begin
        j_q <= j_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      data_q <= data_in_i;
    end
    if (cmd_i.init) begin
      n_q    <= '0;
      kidx_q <= '0;
    end else begin
      if (cmd_i.fill || cmd_i.adv_n) begin
        n_q <= n_nxt;
      end
      if (cmd_i.adv_n) begin
        kidx_q <= kidx_nxt;
      end
    end
    if (cmd_i.adv_n) begin
      pn_q <= n_q;
    end
    if (cmd_i.upd_j) begin
      si_q <= rd_data_q;
    end
    if (cmd_i.wr_j) begin
      sj_q <= rd_data_q;
    end
    if (cmd_i.rd_t) begin
      t_q <= t_val;
    end
  end

  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_q <= data_q ^ 8'(ks);
    end
  end

  assign data_out_o     = out_data_q;
  assign out_valid_o    = out_valid_q;
  assign st_o.n_last    = (n_q == LAST_IDX);
  assign st_o.n_zero    = (n_q == '0);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/rc4_128_stream_cipher_top.sv -----
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o   | data_in_i, first_of_message_i
// out     | output    | out_valid_o/out_ready_i | data_out_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte passes from acceptance through BYTE_B, BYTE_C and FIN to its result,
// and the next byte is accepted in the cycle that result loads; the table's
// one read and one write port (three reads and two swap writes per byte) set
// this. A byte flagged first_of_message first passes the identity fill and the
// keyed swaps. Reset clears the key, i, j and control; the table holds nothing
// until the first key schedule. A stalled result holds in the output register;
// one more byte may be accepted but waits in FIN, holding off further input.
module rc4_128_stream_cipher_top #(
  parameter int unsigned TABLE_SIZE = 128,
  parameter int unsigned KEY_BYTES  = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_in_i,
  input  logic                            first_of_message_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      data_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4s_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rc4s_pkg::cmd_t    cmd;
  rc4s_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  rc4s_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .first_of_message_i (first_of_message_i),
    .in_ready_o         (in_ready_o),
    .st_i               (st),
    .cmd_o              (cmd)
  );

  rc4s_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BYTES  (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .data_in_i   (data_in_i),
    .data_out_o  (data_out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ----- verif/rc4s_cipher_checker.sv -----
`timescale 1ns / 1ps

module rc4s_cipher_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      data_in_i,
  input  logic                            first_of_message_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      data_out_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4s_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int unsigned PERM_SIZE = 128;
  localparam int unsigned PERM_W    = 7;
  localparam int unsigned KEY_LEN   = 30;
  localparam int unsigned DATA_W    = rc4s_pkg::CFG_DATA_W;
  localparam int unsigned KEY3_W    = rc4s_pkg::KEY3_W;

  logic [DATA_W-1:0]     key_reg [4];
  bit   [PERM_W-1:0]     perm [PERM_SIZE];
  bit   [PERM_W-1:0]     idx_i = '0;
  bit   [PERM_W-1:0]     idx_j = '0;
  logic [7:0]            expected_bytes [$];
  logic [7:0]            want;
  int                    n_fail = 0;
  int                    n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  function automatic logic [7:0] key_byte(int unsigned k);
    logic [DATA_W-1:0] word;
    word = key_reg[k / 8] >> (8 * (k % 8));
    return word[7:0];
  endfunction

  function automatic void run_key_schedule();
    int unsigned     j;
    bit [PERM_W-1:0] held;
    for (int unsigned n = 0; n < PERM_SIZE; n++) perm[n] = PERM_W'(n);
    j = 0;
    for (int unsigned n = 0; n < PERM_SIZE; n++) begin
      j = (j + perm[n] + key_byte(n % KEY_LEN)) % PERM_SIZE;
      held    = perm[j];
      perm[j] = perm[n];
      perm[n] = held;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic logic [7:0] cipher_byte(logic [7:0] data, logic first);
    bit [PERM_W-1:0] held;
    bit [PERM_W-1:0] ks_idx;
    if (first) run_key_schedule();
    idx_i       = idx_i + 1'b1;
    idx_j       = idx_j + perm[idx_i];
    held        = perm[idx_j];
    perm[idx_j] = perm[idx_i];
    perm[idx_i] = held;
    ks_idx      = perm[idx_i] + perm[idx_j];
    return data ^ 8'(perm[ks_idx]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (key_reg[w]) key_reg[w] = '0;
      idx_i = '0;
      idx_j = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rc4s_pkg::CFG_KEY_WORD0: key_reg[rc4s_pkg::CFG_KEY_WORD0] = cfg_data_i;
          rc4s_pkg::CFG_KEY_WORD1: key_reg[rc4s_pkg::CFG_KEY_WORD1] = cfg_data_i;
          rc4s_pkg::CFG_KEY_WORD2: key_reg[rc4s_pkg::CFG_KEY_WORD2] = cfg_data_i;
          rc4s_pkg::CFG_KEY_WORD3: begin
            key_reg[rc4s_pkg::CFG_KEY_WORD3] = DATA_W'(cfg_data_i[KEY3_W-1:0]);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("data_out with no request pending: actual %02h", data_out_i);
          n_fail++;
        end else begin
          want = expected_bytes.pop_front();
          if (data_out_i !== want) begin
            $error("data_out mismatch: expected %02h, actual %02h", want, data_out_i);
            n_fail++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_bytes.push_back(cipher_byte(data_in_i, first_of_message_i));
      end
    end
    n_pending = expected_bytes.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDX_W        = rc4s_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W       = rc4s_pkg::CFG_DATA_W;
  localparam int unsigned MSG_ITEMS    = 140;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [IDX_W-1:0] CFG_FIRST_UNUSED = rc4s_pkg::CFG_KEY_WORD3 + 1'b1;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              in_valid_i         = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_in_i          = '0;
  logic              first_of_message_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i        = 1'b0;
  logic [7:0]        data_out_o;
  logic              cfg_valid_i        = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i        = '0;
  logic [DATA_W-1:0] cfg_data_i         = '0;

  int fail_count;
  int pending_reqs;
  int in_idle_pct  = 38;
  int out_idle_pct = 38;
  bit hold_off_req = 1'b0;

  always #1 clk_i = ~clk_i;

  rc4_128_stream_cipher_top dut (.*);

  rc4s_cipher_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .data_in_i          (data_in_i),
    .first_of_message_i (first_of_message_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_out_i         (data_out_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .pending_o          (pending_reqs)
  );

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] data, logic first);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    data_in_i          <= data;
    first_of_message_i <= first;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic program_key(logic [DATA_W-1:0] w0, logic [DATA_W-1:0] w1,
                             logic [DATA_W-1:0] w2, logic [DATA_W-1:0] w3);
    write_reg(rc4s_pkg::CFG_KEY_WORD0, w0);
    write_reg(rc4s_pkg::CFG_KEY_WORD1, w1);
    write_reg(rc4s_pkg::CFG_KEY_WORD2, w2);
    write_reg(rc4s_pkg::CFG_KEY_WORD3, w3);
    for (int k = CFG_FIRST_UNUSED; k < 2 ** IDX_W; k++) begin
      write_reg(IDX_W'(k), {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_reqs != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly whole messages, some stray bytes with a random first flag
  task automatic send_traffic(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 32);
        for (int b = 0; b < len; b++) send_byte(random_byte(), b == 0);
        sent += len;
      end else begin
        send_byte(random_byte(), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, data extremes, restarts
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hC3, 1'b0);
    drain();

    // new key must not touch the message already running
    program_key('1, '1, '1, '1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h81, 1'b0);
    drain();

    program_key({4{16'h55AA}}, {4{16'hAA55}}, {8{8'h0F}}, {8{8'hF0}});
    send_traffic(MSG_ITEMS);
    drain();

    program_key('0, '0, '0, '0);
    hold_off_req = 1'b1;
    send_traffic(MSG_ITEMS);
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    program_key({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    send_traffic(MSG_ITEMS);
    drain();

    in_idle_pct  = 38;
    out_idle_pct = 38;
    program_key({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    send_byte(random_byte(), 1'b0);
    send_traffic(MSG_ITEMS);
    drain();

    program_key({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    send_traffic(MSG_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("rc4_128_stream_cipher_top test passed");
    end else begin
      $display("rc4_128_stream_cipher_top test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("rc4_128_stream_cipher_top test failed");
    $finish;
  end

endmodule
